### rtl/core/isfc_pkg.sv
package isfc_pkg;

  typedef enum logic [1:0] {
    WB8,
    WB12,
    WB16
  } wbits_e;

  typedef enum logic [1:0] {
    KIND_PACKED,
    KIND_CS16,
    KIND_CF32
  } kind_e;

  // decoded format: ok is low for the undefined codes
  typedef struct packed {
    logic   ok;
    wbits_e wb;
    logic   two;
    kind_e  kind;
  } mode_t;

  localparam int unsigned ModeW   = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_FORMAT_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DIRECTION   = 2'd1;

  // format register codes
  localparam logic [ModeW-1:0] FMT_CS8_1W16  = 4'd0;
  localparam logic [ModeW-1:0] FMT_CS16_1W16 = 4'd1;
  localparam logic [ModeW-1:0] FMT_CF32_1W16 = 4'd2;
  localparam logic [ModeW-1:0] FMT_CS12_1W24 = 4'd3;
  localparam logic [ModeW-1:0] FMT_CS16_1W24 = 4'd4;
  localparam logic [ModeW-1:0] FMT_CF32_1W24 = 4'd5;
  localparam logic [ModeW-1:0] FMT_CS16_1W32 = 4'd6;
  localparam logic [ModeW-1:0] FMT_CS12_2W48 = 4'd7;
  localparam logic [ModeW-1:0] FMT_CS16_2W48 = 4'd8;
  localparam logic [ModeW-1:0] FMT_CF32_2W48 = 4'd9;
  localparam logic [ModeW-1:0] FMT_CS16_2W64 = 4'd10;
  localparam logic [ModeW-1:0] FMT_CF32_2W64 = 4'd11;

  localparam logic [7:0] NibHiMask = 8'hf0;
  localparam logic [16:0] LimWide  = 17'd32768;  // 1 << 15
  localparam logic [16:0] LimNarrow = 17'd128;   // 1 << 7

  function automatic mode_t decode_mode(input logic [ModeW-1:0] m);
    mode_t r;
    r = '{ok: 1'b1, wb: WB8, two: 1'b0, kind: KIND_PACKED};
    case (m)
      FMT_CS8_1W16:  r = '{ok: 1'b1, wb: WB8,  two: 1'b0, kind: KIND_PACKED};
      FMT_CS16_1W16: r = '{ok: 1'b1, wb: WB8,  two: 1'b0, kind: KIND_CS16};
      FMT_CF32_1W16: r = '{ok: 1'b1, wb: WB8,  two: 1'b0, kind: KIND_CF32};
      FMT_CS12_1W24: r = '{ok: 1'b1, wb: WB12, two: 1'b0, kind: KIND_PACKED};
      FMT_CS16_1W24: r = '{ok: 1'b1, wb: WB12, two: 1'b0, kind: KIND_CS16};
      FMT_CF32_1W24: r = '{ok: 1'b1, wb: WB12, two: 1'b0, kind: KIND_CF32};
      FMT_CS16_1W32: r = '{ok: 1'b1, wb: WB16, two: 1'b0, kind: KIND_CS16};
      FMT_CS12_2W48: r = '{ok: 1'b1, wb: WB12, two: 1'b1, kind: KIND_PACKED};
      FMT_CS16_2W48: r = '{ok: 1'b1, wb: WB12, two: 1'b1, kind: KIND_CS16};
      FMT_CF32_2W48: r = '{ok: 1'b1, wb: WB12, two: 1'b1, kind: KIND_CF32};
      FMT_CS16_2W64: r = '{ok: 1'b1, wb: WB16, two: 1'b1, kind: KIND_CS16};
      FMT_CF32_2W64: r = '{ok: 1'b1, wb: WB16, two: 1'b1, kind: KIND_CF32};
      default: r = '{ok: 1'b0, wb: WB8, two: 1'b0, kind: KIND_PACKED};
    endcase
    return r;
  endfunction

endpackage

### rtl/core/isfc_lane.sv
// one I or Q component: int to float and float to saturated int, two stages
module isfc_lane (
  input  logic        clk_i,
  input  logic        en_a_i,
  input  logic        en_b_i,
  input  logic        narrow_i,
  input  logic        cf32_i,
  input  logic [15:0] comp_i,
  input  logic [31:0] host_i,
  output logic [31:0] host_word_o,
  output logic [15:0] wire_comp_o,
  output logic        clip_o
);

  // stage a decode
  logic        sgn_d;
  logic [15:0] mag_d;
  logic [7:0]  fexp;
  logic [9:0]  sh;
  logic        nan_d, big_d, zero_d;

  always_comb begin
    sgn_d  = comp_i[15];
    mag_d  = comp_i[15] ? (16'd0 - comp_i) : comp_i;
    fexp   = host_i[30:23];
    sh     = {2'b00, fexp} + (narrow_i ? 10'd7 : 10'd15) - 10'd127;
    nan_d  = (fexp == 8'hff) && (host_i[22:0] != 23'd0);
    zero_d = (fexp == 8'd0) || sh[9];
    big_d  = !zero_d && (sh > 10'd16);
  end

  logic        sgn_q, fsgn_q, nan_q, big_q, zero_q, narrow_q, cf32_q;
  logic [15:0] mag_q, comp_q, hlo_q;
  logic [23:0] mant_q;
  logic [4:0]  shamt_q;

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      sgn_q    <= sgn_d;
      mag_q    <= mag_d;
      comp_q   <= comp_i;
      hlo_q    <= host_i[15:0];
      fsgn_q   <= host_i[31];
      nan_q    <= nan_d;
      big_q    <= big_d;
      zero_q   <= zero_d;
      mant_q   <= {1'b1, host_i[22:0]};
      shamt_q  <= sh[4:0];
      narrow_q <= narrow_i;
      cf32_q   <= cf32_i;
    end
  end

  // stage b: normalize and saturate
  logic [3:0]  lead;
  logic [15:0] norm;
  logic [7:0]  iexp;
  logic [31:0] fword;
  logic [23:0] tval;
  logic [16:0] lim, tmag;
  logic [15:0] ival, wcomp;
  logic        sat;

  always_comb begin
    lead = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (mag_q[k]) lead = 4'(k);
    end
    norm  = mag_q << (4'd15 - lead);
    iexp  = {4'd0, lead} + (narrow_q ? 8'd120 : 8'd112);
    fword = (mag_q == 16'd0) ? 32'd0 : {sgn_q, iexp, norm[14:0], 8'd0};

    tval = zero_q ? 24'd0 : (mant_q >> (5'd23 - shamt_q));
    tmag = tval[16:0];
    lim  = narrow_q ? isfc_pkg::LimNarrow : isfc_pkg::LimWide;
    sat  = 1'b0;
    if (nan_q) begin
      ival = 16'd0;
      sat  = 1'b1;
    end else if (!fsgn_q) begin
      if (big_q || tmag >= lim) begin
        ival = 16'(lim - 17'd1);
        sat  = 1'b1;
      end else begin
        ival = tmag[15:0];
      end
    end else begin
      if (big_q || tmag > lim) begin
        ival = 16'(17'd0 - lim);
        sat  = 1'b1;
      end else begin
        ival = 16'(17'd0 - tmag);
      end
    end
    wcomp = cf32_q ? ival : hlo_q;
    if (narrow_q) wcomp = {8'd0, wcomp[7:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      host_word_o <= cf32_q ? fword : {16'd0, comp_q};
      wire_comp_o <= wcomp;
      clip_o      <= cf32_q & sat;
    end
  end

endmodule

### rtl/core/iq_sample_format_converter_core.sv
// channel | dir | signals                                 | beat
// in      | in  | in_valid_i, in_stall_o, wire/host/last  | one frame
// out     | out | out_valid_o, out_stall_i, wire/host/... | one frame
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i         | one register
//
// one frame per cycle sustained while out_stall_i is low; a beat passes four
// register stages before out_valid_o rises
// stages: input regs, component decode, normalize/saturate, pack into output regs
// each stage loads when empty or when the next stage moves, so bubbles collapse
// and the input keeps taking beats under out_stall_i until all four stages hold one
// rst_ni clears valid bits and the config registers (mode 0, wire to host)
module iq_sample_format_converter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [isfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [isfc_pkg::ModeW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [63:0]                   wire_in_i,
  input  logic [31:0]                   host_a_i_in_i,
  input  logic [31:0]                   host_a_q_in_i,
  input  logic [31:0]                   host_b_i_in_i,
  input  logic [31:0]                   host_b_q_in_i,
  input  logic                          frame_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [63:0]                   wire_out_o,
  output logic [31:0]                   host_a_i_out_o,
  output logic [31:0]                   host_a_q_out_o,
  output logic [31:0]                   host_b_i_out_o,
  output logic [31:0]                   host_b_q_out_o,
  output logic                          clipped_o,
  output logic                          last_out_o
);

  // config registers
  logic [isfc_pkg::ModeW-1:0] format_mode_q;
  logic                       direction_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_mode_q <= '0;
      direction_q   <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == isfc_pkg::REG_FORMAT_MODE) format_mode_q <= cfg_wdata_i;
      if (cfg_idx_i == isfc_pkg::REG_DIRECTION)   direction_q   <= cfg_wdata_i[0];
    end
  end

  // valid chain and per-stage advance
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_q || !out_stall_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o  = !adv1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // stage 1: input capture with the decoded mode
  isfc_pkg::mode_t md1_q, md2_q, md3_q;
  logic        dir1_q, dir2_q, dir3_q;
  logic        last1_q, last2_q, last3_q;
  logic [63:0] wire1_q;
  logic [31:0] ha_i1_q, ha_q1_q, hb_i1_q, hb_q1_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      md1_q   <= isfc_pkg::decode_mode(format_mode_q);
      dir1_q  <= direction_q;
      last1_q <= frame_last_i;
      wire1_q <= wire_in_i;
      ha_i1_q <= host_a_i_in_i;
      ha_q1_q <= host_a_q_in_i;
      hb_i1_q <= host_b_i_in_i;
      hb_q1_q <= host_b_q_in_i;
    end
  end

  // split the wire word into channel slots and components
  logic [31:0] w0, w1;
  logic [15:0] c0i, c0q, c1i, c1q;
  logic [23:0] pk1_d0, pk1_d1;
  logic        narrow1, cf32_1;

  function automatic logic [31:0] comps(input logic [31:0] w, input isfc_pkg::wbits_e wb);
    logic [15:0] ci, cq;
    case (wb)
      isfc_pkg::WB8: begin
        ci = {{8{w[7]}}, w[7:0]};
        cq = {{8{w[15]}}, w[15:8]};
      end
      isfc_pkg::WB12: begin
        ci = {w[11:8], w[7:0], 4'd0};
        cq = {w[23:16], w[15:12], 4'd0};
      end
      default: begin
        ci = w[15:0];
        cq = w[31:16];
      end
    endcase
    return {cq, ci};
  endfunction

  always_comb begin
    case (md1_q.wb)
      isfc_pkg::WB8:  w0 = {16'd0, wire1_q[15:0]};
      isfc_pkg::WB12: w0 = {8'd0, wire1_q[23:0]};
      default:        w0 = wire1_q[31:0];
    endcase
    w1 = (md1_q.wb == isfc_pkg::WB12) ? {8'd0, wire1_q[47:24]} : wire1_q[63:32];
    {c0q, c0i} = comps(w0, md1_q.wb);
    {c1q, c1i} = comps(w1, md1_q.wb);
    narrow1 = (md1_q.wb == isfc_pkg::WB8);
    cf32_1  = (md1_q.kind == isfc_pkg::KIND_CF32);
    // packed frames pass through as bytes
    if (!dir1_q) begin
      pk1_d0 = w0[23:0];
      pk1_d1 = w1[23:0];
    end else begin
      pk1_d0 = narrow1 ? {8'd0, ha_i1_q[15:0]} : ha_i1_q[23:0];
      pk1_d1 = narrow1 ? {8'd0, hb_i1_q[15:0]} : hb_i1_q[23:0];
    end
  end

  // stages 2 and 3: control and packed bytes ride alongside the lanes
  logic [23:0] pk0_2_q, pk1_2_q, pk0_3_q, pk1_3_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      md2_q   <= md1_q;
      dir2_q  <= dir1_q;
      last2_q <= last1_q;
      pk0_2_q <= pk1_d0;
      pk1_2_q <= pk1_d1;
    end
    if (adv3) begin
      md3_q   <= md2_q;
      dir3_q  <= dir2_q;
      last3_q <= last2_q;
      pk0_3_q <= pk0_2_q;
      pk1_3_q <= pk1_2_q;
    end
  end

  logic [31:0] hw0, hw1, hw2, hw3;
  logic [15:0] wc0, wc1, wc2, wc3;
  logic        cl0, cl1, cl2, cl3;

  isfc_lane u_lane_ai (
    .clk_i, .en_a_i(adv2), .en_b_i(adv3), .narrow_i(narrow1), .cf32_i(cf32_1),
    .comp_i(c0i), .host_i(ha_i1_q), .host_word_o(hw0), .wire_comp_o(wc0), .clip_o(cl0)
  );
  isfc_lane u_lane_aq (
    .clk_i, .en_a_i(adv2), .en_b_i(adv3), .narrow_i(narrow1), .cf32_i(cf32_1),
    .comp_i(c0q), .host_i(ha_q1_q), .host_word_o(hw1), .wire_comp_o(wc1), .clip_o(cl1)
  );
  isfc_lane u_lane_bi (
    .clk_i, .en_a_i(adv2), .en_b_i(adv3), .narrow_i(narrow1), .cf32_i(cf32_1),
    .comp_i(c1i), .host_i(hb_i1_q), .host_word_o(hw2), .wire_comp_o(wc2), .clip_o(cl2)
  );
  isfc_lane u_lane_bq (
    .clk_i, .en_a_i(adv2), .en_b_i(adv3), .narrow_i(narrow1), .cf32_i(cf32_1),
    .comp_i(c1q), .host_i(hb_q1_q), .host_word_o(hw3), .wire_comp_o(wc3), .clip_o(cl3)
  );

  // stage 4: assemble the frame into the output registers
  function automatic logic [31:0] pack_ch(input logic [15:0] ci, input logic [15:0] cq,
                                          input isfc_pkg::wbits_e wb);
    logic [31:0] r;
    case (wb)
      isfc_pkg::WB8:  r = {16'd0, cq[7:0], ci[7:0]};
      isfc_pkg::WB12: r = {8'd0, cq[15:8], (cq[7:0] & isfc_pkg::NibHiMask) | {4'd0, ci[15:12]},
                           ci[11:4]};
      default:        r = {cq, ci};
    endcase
    return r;
  endfunction

  logic [63:0] wire_d;
  logic [31:0] hai_d, haq_d, hbi_d, hbq_d, ch0, ch1;
  logic        clip_d, packed3;

  always_comb begin
    wire_d  = '0;
    hai_d   = '0;
    haq_d   = '0;
    hbi_d   = '0;
    hbq_d   = '0;
    clip_d  = 1'b0;
    packed3 = (md3_q.kind == isfc_pkg::KIND_PACKED);
    ch0 = packed3 ? {8'd0, pk0_3_q} : pack_ch(wc0, wc1, md3_q.wb);
    ch1 = packed3 ? {8'd0, pk1_3_q} : pack_ch(wc2, wc3, md3_q.wb);
    if (md3_q.ok) begin
      if (!dir3_q) begin
        hai_d = packed3 ? {8'd0, pk0_3_q} : hw0;
        haq_d = packed3 ? 32'd0 : hw1;
        if (md3_q.two) begin
          hbi_d = packed3 ? {8'd0, pk1_3_q} : hw2;
          hbq_d = packed3 ? 32'd0 : hw3;
        end
      end else begin
        clip_d = !packed3 && (cl0 || cl1 || (md3_q.two && (cl2 || cl3)));
        case (md3_q.wb)
          isfc_pkg::WB8:  wire_d = {48'd0, ch0[15:0]};
          isfc_pkg::WB12: wire_d = md3_q.two ? {16'd0, ch1[23:0], ch0[23:0]}
                                             : {40'd0, ch0[23:0]};
          default:        wire_d = md3_q.two ? {ch1, ch0} : {32'd0, ch0};
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      wire_out_o     <= wire_d;
      host_a_i_out_o <= hai_d;
      host_a_q_out_o <= haq_d;
      host_b_i_out_o <= hbi_d;
      host_b_q_out_o <= hbq_d;
      clipped_o      <= clip_d;
      last_out_o     <= last3_q;
    end
  end

  // the input only stalls when every stage holds a frame
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with a free pipeline stage");

  // a held frame in stage one is not dropped
  a_hold_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv2) |=> v1_q)
    else $error("stage one frame lost while blocked");

  // clipping only on the host to wire path, where host words are zero
  a_clip_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |-> (host_a_i_out_o == 32'd0 && host_b_i_out_o == 32'd0))
    else $error("clipped set on a wire to host frame");

  // wire and host outputs are never both populated
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && wire_out_o != 64'd0) |-> (host_a_i_out_o == 32'd0 &&
      host_a_q_out_o == 32'd0 && host_b_i_out_o == 32'd0 && host_b_q_out_o == 32'd0))
    else $error("wire and host outputs both driven");

endmodule

### verif/iq_sample_format_converter_core_tb.sv
`timescale 1ns / 100ps

module iq_sample_format_converter_core_tb;

  // format codes as written into the format register
  localparam logic [3:0] M_CS8_1W16  = isfc_pkg::FMT_CS8_1W16;
  localparam logic [3:0] M_CS16_1W16 = isfc_pkg::FMT_CS16_1W16;
  localparam logic [3:0] M_CF32_1W16 = isfc_pkg::FMT_CF32_1W16;
  localparam logic [3:0] M_CS12_1W24 = isfc_pkg::FMT_CS12_1W24;
  localparam logic [3:0] M_CS16_1W24 = isfc_pkg::FMT_CS16_1W24;
  localparam logic [3:0] M_CF32_1W24 = isfc_pkg::FMT_CF32_1W24;
  localparam logic [3:0] M_CS16_1W32 = isfc_pkg::FMT_CS16_1W32;
  localparam logic [3:0] M_CS12_2W48 = isfc_pkg::FMT_CS12_2W48;
  localparam logic [3:0] M_CS16_2W48 = isfc_pkg::FMT_CS16_2W48;
  localparam logic [3:0] M_CF32_2W48 = isfc_pkg::FMT_CF32_2W48;
  localparam logic [3:0] M_CS16_2W64 = isfc_pkg::FMT_CS16_2W64;
  localparam logic [3:0] M_CF32_2W64 = isfc_pkg::FMT_CF32_2W64;
  localparam logic [3:0] M_UNDEF_LO  = 4'd12;
  localparam logic [3:0] M_UNDEF_HI  = 4'd15;
  localparam logic       DIR_W2H     = 1'b0;
  localparam logic       DIR_H2W     = 1'b1;

  localparam logic [31:0] F32_ONE     = 32'h3f800000;
  localparam logic [31:0] F32_NEG_ONE = 32'hbf800000;
  localparam logic [31:0] F32_NAN     = 32'h7fc00000;
  localparam logic [31:0] F32_POS_INF = 32'h7f800000;
  localparam logic [31:0] F32_NEG_INF = 32'hff800000;

  typedef struct packed {
    logic [63:0] wire_w;
    logic [31:0] ai, aq, bi, bq;
    logic        last;
  } frame_in_t;

  typedef struct packed {
    logic [63:0] wire_w;
    logic [31:0] ai, aq, bi, bq;
    logic        clip;
    logic        last;
  } frame_res_t;

  typedef struct packed {
    logic [3:0] mode;
    logic       dir;
    frame_in_t  x;
    logic       known;
    frame_res_t r;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [isfc_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [isfc_pkg::ModeW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [63:0] wire_in_i = '0;
  logic [31:0] host_a_i_in_i = '0, host_a_q_in_i = '0, host_b_i_in_i = '0, host_b_q_in_i = '0;
  logic frame_last_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [63:0] wire_out_o;
  logic [31:0] host_a_i_out_o, host_a_q_out_o, host_b_i_out_o, host_b_q_out_o;
  logic clipped_o, last_out_o;

  iq_sample_format_converter_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .wire_in_i     (wire_in_i),
    .host_a_i_in_i (host_a_i_in_i),
    .host_a_q_in_i (host_a_q_in_i),
    .host_b_i_in_i (host_b_i_in_i),
    .host_b_q_in_i (host_b_q_in_i),
    .frame_last_i  (frame_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .wire_out_o    (wire_out_o),
    .host_a_i_out_o(host_a_i_out_o),
    .host_a_q_out_o(host_a_q_out_o),
    .host_b_i_out_o(host_b_i_out_o),
    .host_b_q_out_o(host_b_q_out_o),
    .clipped_o     (clipped_o),
    .last_out_o    (last_out_o)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  frame_res_t conv_q[$];      // converted frames still owed by the block
  logic [3:0] cur_mode = M_CS8_1W16;
  logic       cur_dir  = DIR_W2H;
  bit         idle_en  = 1'b1;
  bit         hold_go  = 1'b0;
  int         errors   = 0;
  int         n_frames = 0;
  int         n_clip   = 0;
  int         n_sat_hold = 0;
  bit [15:0]  modes_w2h = '0, modes_h2w = '0;

  // signed component -> host word: cs16 pattern or exact float scaled by 2^-k
  function automatic logic [31:0] comp_to_host(int v, isfc_pkg::kind_e kind, int k);
    int mag, p, ex;
    logic [31:0] mant;
    if (kind != isfc_pkg::KIND_CF32) return v & 32'hffff;
    if (v == 0) return 32'h0;
    mag = (v < 0) ? -v : v;
    p = 0;
    for (int b = 0; b < 17; b++) if (mag[b]) p = b;
    ex = p - k + 127;
    mant = (mag << (23 - p)) & 32'h7fffff;
    return {v < 0, ex[7:0], mant[22:0]};
  endfunction

  // float bits * 2^k, truncated toward zero, saturated; nan gives 0
  function automatic logic [15:0] f32_to_comp(logic [31:0] f, bit narrow, inout logic clip);
    int k, hi, ex, sh, v;
    longint t;
    logic [23:0] m;
    k  = narrow ? 7 : 15;
    hi = narrow ? 127 : 32767;
    ex = f[30:23];
    m  = (ex != 0) ? {1'b1, f[22:0]} : {1'b0, f[22:0]};
    if (ex == 255) begin
      clip = 1'b1;
      if (f[22:0] != 0) v = 0;
      else v = f[31] ? -(hi + 1) : hi;
    end else begin
      sh = ((ex == 0) ? 1 : ex) - 150 + k;
      if (sh > 30) t = 64'd1 << 40;
      else if (sh >= 0) t = longint'(m) << sh;
      else if (sh <= -25) t = 0;
      else t = longint'(m) >> (-sh);
      if (!f[31]) begin
        if (t >= hi + 1) begin v = hi; clip = 1'b1; end
        else v = int'(t);
      end else begin
        if (t >= hi + 2) begin v = -(hi + 1); clip = 1'b1; end
        else v = -int'(t);
      end
    end
    return narrow ? 16'(v & 32'h00ff) : v[15:0];
  endfunction

  function automatic frame_res_t convert_frame(frame_in_t x, logic [3:0] mode, logic dir);
    frame_res_t r;
    int wb, slot, nch, iv, qv;
    isfc_pkg::kind_e kind;
    logic [63:0] mask, w;
    logic [31:0] h[4];
    logic [31:0] hi_w, hq_w;
    logic [15:0] ip, qp;
    logic clip;
    r = '0;
    r.last = x.last;
    h = '{default: '0};
    clip = 1'b0;
    case (mode)
      M_CS8_1W16:  begin wb = 8;  nch = 1; kind = isfc_pkg::KIND_PACKED; end
      M_CS16_1W16: begin wb = 8;  nch = 1; kind = isfc_pkg::KIND_CS16;   end
      M_CF32_1W16: begin wb = 8;  nch = 1; kind = isfc_pkg::KIND_CF32;   end
      M_CS12_1W24: begin wb = 12; nch = 1; kind = isfc_pkg::KIND_PACKED; end
      M_CS16_1W24: begin wb = 12; nch = 1; kind = isfc_pkg::KIND_CS16;   end
      M_CF32_1W24: begin wb = 12; nch = 1; kind = isfc_pkg::KIND_CF32;   end
      M_CS16_1W32: begin wb = 16; nch = 1; kind = isfc_pkg::KIND_CS16;   end
      M_CS12_2W48: begin wb = 12; nch = 2; kind = isfc_pkg::KIND_PACKED; end
      M_CS16_2W48: begin wb = 12; nch = 2; kind = isfc_pkg::KIND_CS16;   end
      M_CF32_2W48: begin wb = 12; nch = 2; kind = isfc_pkg::KIND_CF32;   end
      M_CS16_2W64: begin wb = 16; nch = 2; kind = isfc_pkg::KIND_CS16;   end
      M_CF32_2W64: begin wb = 16; nch = 2; kind = isfc_pkg::KIND_CF32;   end
      default: return r;   // undefined format: all zero, last still copied
    endcase
    slot = (wb == 8) ? 16 : (wb == 12) ? 24 : 32;
    mask = (64'd1 << slot) - 1;
    for (int c = 0; c < nch; c++) begin
      hi_w = c ? x.bi : x.ai;
      hq_w = c ? x.bq : x.aq;
      if (dir == DIR_W2H) begin
        w = (x.wire_w >> (c * slot)) & mask;
        if (kind == isfc_pkg::KIND_PACKED) begin
          h[2*c] = w[31:0];
          continue;
        end
        if (wb == 8) begin
          iv = $signed(w[7:0]);
          qv = $signed(w[15:8]);
        end else begin
          if (wb == 12) begin
            // 12-bit samples come out left-justified in 16 bits
            ip = {w[11:8], w[7:0], 4'h0};
            qp = {w[23:16], w[15:12], 4'h0};
          end else begin
            ip = w[15:0];
            qp = w[31:16];
          end
          iv = $signed(ip);
          qv = $signed(qp);
        end
        h[2*c]   = comp_to_host(iv, kind, (wb == 8) ? 7 : 15);
        h[2*c+1] = comp_to_host(qv, kind, (wb == 8) ? 7 : 15);
      end else begin
        if (kind == isfc_pkg::KIND_PACKED) w = {32'h0, hi_w} & mask;
        else begin
          if (kind == isfc_pkg::KIND_CF32) begin
            ip = f32_to_comp(hi_w, wb == 8, clip);
            qp = f32_to_comp(hq_w, wb == 8, clip);
          end else begin
            ip = hi_w[15:0];
            qp = hq_w[15:0];
          end
          if (wb == 8) w = {48'h0, qp[7:0], ip[7:0]};
          else if (wb == 12) w = {40'h0, qp[15:8], qp[7:4], ip[15:12], ip[11:4]};
          else w = {32'h0, qp, ip};
        end
        r.wire_w |= (w & mask) << (c * slot);
      end
    end
    r.ai = h[0];
    r.aq = h[1];
    r.bi = h[2];
    r.bq = h[3];
    r.clip = clip;
    return r;
  endfunction

  // floats mostly around the converter's range, plus specials and raw bits
  function automatic logic [31:0] pick_f32();
    logic [7:0] ex;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 6))
          0: return 32'h0;
          1: return 32'h80000000;
          2: return F32_NAN | $urandom_range(0, 32'h3fffff);
          3: return F32_POS_INF;
          4: return F32_NEG_INF;
          5: return $urandom_range(1, 32'h7fffff);
          default: return F32_ONE;
        endcase
      end
      default: begin
        ex = 8'($urandom_range(110, 128));
        return {1'($urandom), ex, 23'($urandom)};
      end
    endcase
  endfunction

  task automatic write_reg(logic [isfc_pkg::CfgIdxW-1:0] idx,
                           logic [isfc_pkg::ModeW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk);
    cfg_we_i    <= 1'b0;
  endtask

  // only called with no beat in flight
  task automatic set_format(logic [3:0] mode, logic dir);
    write_reg(isfc_pkg::REG_FORMAT_MODE, mode);
    write_reg(isfc_pkg::REG_DIRECTION, isfc_pkg::ModeW'(dir));
    cur_mode = mode;
    cur_dir  = dir;
  endtask

  // lets the pipe empty: waits until no converted frame is still owed, then a margin
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (conv_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_frame(frame_in_t x, logic known, frame_res_t r);
    wire_in_i     <= x.wire_w;
    host_a_i_in_i <= x.ai;
    host_a_q_in_i <= x.aq;
    host_b_i_in_i <= x.bi;
    host_b_q_in_i <= x.bq;
    frame_last_i  <= x.last;
    in_valid_i    <= 1'b1;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    conv_q.push_back(known ? r : convert_frame(x, cur_mode, cur_dir));
    if (cur_dir == DIR_W2H) modes_w2h[cur_mode] = 1'b1;
    else modes_h2w[cur_mode] = 1'b1;
    // random sender gap
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // receiver stall: random bursts, plus one long hold-off on request
  initial begin : recv_stall
    int burst, hold;
    burst = 0;
    hold  = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold = 300;
        n_sat_hold++;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (!idle_en) begin
        burst = 0;
        out_stall_i <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 19) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
    end
  endtask

  // result checker: each output beat against the oldest owed frame
  always @(posedge clk) begin
    frame_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (conv_q.size() == 0) begin
        errors++;
        $display("%0t: output beat with nothing expected, expected none actual %h",
                 $time, wire_out_o);
      end else begin
        e = conv_q.pop_front();
        n_frames++;
        if (clipped_o === 1'b1) n_clip++;
        check_field("wire_out", e.wire_w, wire_out_o);
        check_field("host_a_i_out", e.ai, host_a_i_out_o);
        check_field("host_a_q_out", e.aq, host_a_q_out_o);
        check_field("host_b_i_out", e.bi, host_b_i_out_o);
        check_field("host_b_q_out", e.bq, host_b_q_out_o);
        check_field("clipped", e.clip, clipped_o);
        check_field("last_out", e.last, last_out_o);
      end
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stim
    stim_row_t tab[$];
    frame_in_t x;
    logic [3:0] m;
    logic d;

    // directed rows; known expectations only where they are obvious
    tab.push_back('{M_CS8_1W16, DIR_W2H, '{64'hffff_ffff_ffff_abcd, 0, 0, 0, 0, 1'b0},
                    1'b1, '{64'h0, 32'habcd, 0, 0, 0, 1'b0, 1'b0}});
    tab.push_back('{M_CS16_1W16, DIR_W2H, '{64'h807f, 0, 0, 0, 0, 1'b1},
                    1'b1, '{64'h0, 32'h007f, 32'hff80, 0, 0, 1'b0, 1'b1}});
    tab.push_back('{M_CF32_1W16, DIR_W2H, '{64'h8001, 0, 0, 0, 0, 1'b0}, 1'b0, '0});
    tab.push_back('{M_CS12_1W24, DIR_W2H, '{64'hffff_ffff, 0, 0, 0, 0, 1'b0},
                    1'b1, '{64'h0, 32'hff_ffff, 0, 0, 0, 1'b0, 1'b0}});
    tab.push_back('{M_CS16_1W24, DIR_W2H, '{64'h123456, 0, 0, 0, 0, 1'b0}, 1'b0, '0});
    tab.push_back('{M_CF32_1W24, DIR_W2H, '{64'h800_7ff, 0, 0, 0, 0, 1'b0}, 1'b0, '0});
    tab.push_back('{M_CS16_1W32, DIR_W2H, '{64'h8000_7fff, 0, 0, 0, 0, 1'b0},
                    1'b1, '{64'h0, 32'h7fff, 32'h8000, 0, 0, 1'b0, 1'b0}});
    tab.push_back('{M_CS12_2W48, DIR_W2H, '{64'h0000_abcdef_123456, 0, 0, 0, 0, 1'b0},
                    1'b0, '0});
    tab.push_back('{M_CS16_2W64, DIR_W2H, '{64'hffff_ffff_ffff_ffff, 0, 0, 0, 0, 1'b0},
                    1'b0, '0});
    tab.push_back('{M_CF32_2W64, DIR_W2H, '{64'h8000_7fff_0001_ffff, 0, 0, 0, 0, 1'b0},
                    1'b0, '0});
    // undefined formats give all zero, last still copied
    tab.push_back('{M_UNDEF_LO, DIR_W2H, '{64'hffff_ffff_ffff_ffff, '1, '1, '1, '1, 1'b1},
                    1'b1, '{64'h0, 0, 0, 0, 0, 1'b0, 1'b1}});
    tab.push_back('{M_UNDEF_HI, DIR_H2W, '{64'hffff_ffff_ffff_ffff, F32_NAN, F32_NAN, '1, '1,
                    1'b0}, 1'b1, '{64'h0, 0, 0, 0, 0, 1'b0, 1'b0}});
    tab.push_back('{M_CS8_1W16, DIR_H2W, '{64'h0, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 1'b0},
                    1'b1, '{64'hffff, 0, 0, 0, 0, 1'b0, 1'b0}});
    tab.push_back('{M_CS16_1W16, DIR_H2W, '{64'h0, 32'h1234_5678, 32'h0000_ff9a, 0, 0, 1'b0},
                    1'b1, '{64'h9a78, 0, 0, 0, 0, 1'b0, 1'b0}});
    // +1.0 saturates on an 8-bit wire, -1.0 just fits
    tab.push_back('{M_CF32_1W16, DIR_H2W, '{64'h0, F32_ONE, F32_NEG_ONE, 0, 0, 1'b1},
                    1'b1, '{64'h807f, 0, 0, 0, 0, 1'b1, 1'b1}});
    tab.push_back('{M_CS12_1W24, DIR_H2W, '{64'h0, 32'hffff_ffff, 0, 0, 0, 1'b0},
                    1'b1, '{64'hff_ffff, 0, 0, 0, 0, 1'b0, 1'b0}});
    tab.push_back('{M_CS16_1W24, DIR_H2W, '{64'h0, 32'h8000, 32'h7fff, 0, 0, 1'b0}, 1'b0, '0});
    // nan and infinity on a 12-bit wire
    tab.push_back('{M_CF32_1W24, DIR_H2W, '{64'h0, F32_NAN, F32_POS_INF, 0, 0, 1'b0},
                    1'b0, '0});
    tab.push_back('{M_CS16_1W32, DIR_H2W, '{64'h0, 32'hdead_8000, 32'hbeef_7fff, 0, 0, 1'b0},
                    1'b1, '{64'h7fff_8000, 0, 0, 0, 0, 1'b0, 1'b0}});
    tab.push_back('{M_CS12_2W48, DIR_H2W, '{64'h0, 32'hffff_ffff, 0, 32'h0012_3456, 0, 1'b0},
                    1'b0, '0});
    tab.push_back('{M_CS16_2W48, DIR_H2W, '{64'h0, 32'h8000, 32'h7fff, 32'hffff, 32'h0001,
                    1'b0}, 1'b0, '0});
    // -inf, a denormal, +-0.5
    tab.push_back('{M_CF32_2W48, DIR_H2W, '{64'h0, F32_NEG_INF, 32'h1, 32'h3f00_0000,
                    32'hbf00_0000, 1'b0}, 1'b0, '0});
    tab.push_back('{M_CS16_2W64, DIR_H2W, '{64'h0, 32'h1111_2222, 32'h3333_4444,
                    32'h5555_6666, 32'h7777_8888, 1'b0}, 1'b0, '0});
    // just below 1.0 and just past -1.0, then 1.0 and just inside -1.0
    tab.push_back('{M_CF32_2W64, DIR_H2W, '{64'h0, 32'h3f7f_ffff, 32'hbf80_0001,
                    32'h3f80_0000, 32'hbf7f_ffff, 1'b1}, 1'b0, '0});

    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed rows; reformat only with the pipe empty
    set_format(M_CS8_1W16, DIR_W2H);
    foreach (tab[i]) begin
      if (tab[i].mode != cur_mode || tab[i].dir != cur_dir) begin
        drain_pipe();
        set_format(tab[i].mode, tab[i].dir);
      end
      send_frame(tab[i].x, tab[i].known, tab[i].r);
    end
    drain_pipe();

    // random phases, each under one format
    for (int ph = 0; ph < 16; ph++) begin
      case (ph)
        0: begin m = M_CS8_1W16;  d = DIR_W2H; end
        1: begin m = M_CF32_2W64; d = DIR_H2W; end
        2: begin m = M_UNDEF_HI;  d = 1'($urandom); end
        default: begin m = 4'($urandom_range(0, 13)); d = 1'($urandom); end
      endcase
      set_format(m, d);
      // long receiver hold-off so the pipe backs up into the input
      if (ph == 4) hold_go = 1'b1;
      // tail of the run with no idling
      if (ph == 15) idle_en = 1'b0;
      for (int n = 0; n < 32; n++) begin
        x.wire_w = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) begin
          x.ai = $urandom;
          x.aq = $urandom;
          x.bi = $urandom;
          x.bq = $urandom;
        end else begin
          x.ai = pick_f32();
          x.aq = pick_f32();
          x.bi = pick_f32();
          x.bq = pick_f32();
        end
        x.last = ($urandom_range(0, 7) == 0);
        send_frame(x, 1'b0, '0);
      end
      drain_pipe();
    end

    $display("covered %0d frames, %0d clipped, long hold-offs %0d", n_frames, n_clip,
             n_sat_hold);
    $display("formats seen wire-to-host %b, host-to-wire %b", modes_w2h, modes_h2w);
    if (errors == 0 && conv_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
